// ===== hw/rtl/srmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmq_pkg
// Shared types, codes and defaults for the selective-receive mailbox.
// ----------------------------------------------------------------------------
package srmq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int ID_W            = 32;
  localparam int HANDLE_W        = 16;
  localparam int STATUS_W        = 3;
  localparam int FILL_W          = 5;
  localparam int CFG_IDX_W       = 1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_RECEIVED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_RECV = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QUIT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WILDCARD = 1'b1;

  // command word from the front part to the back part
  typedef struct packed {
    logic             opcode;
    logic [ID_W-1:0]  new_id;
    logic [HANDLE_W-1:0] new_handle;
    logic [ID_W-1:0]  range_low;
    logic [ID_W-1:0]  range_high;
    logic             take_out;
    logic             any;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_READ, S_SHIFT, S_DONE
  } state_t;

endpackage

// ===== hw/rtl/srmq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmq_front
// Accepts input words, classifies the receive wildcard and queues commands.
// ----------------------------------------------------------------------------
module srmq_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_opcode,
  input  logic [srmq_pkg::ID_W-1:0]  in_new_id,
  input  logic [srmq_pkg::HANDLE_W-1:0] in_new_handle,
  input  logic [srmq_pkg::ID_W-1:0]  in_range_low,
  input  logic [srmq_pkg::ID_W-1:0]  in_range_high,
  input  logic                       in_take_out,
  input  logic [srmq_pkg::ID_W-1:0]  wildcard_code,
  output logic                       cmd_valid,
  input  logic                       cmd_pop,
  output srmq_pkg::cmd_t             cmd
);
  import srmq_pkg::*;

  // two-entry command queue
  cmd_t       q_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r;
  cmd_t       c;
  logic       push;

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];

  // classify the word
  always_comb begin
    c.opcode     = in_opcode;
    c.new_id     = in_new_id;
    c.new_handle = in_new_handle;
    c.range_low  = in_range_low;
    c.range_high = in_range_high;
    c.take_out   = in_take_out;
    c.any        = (in_range_low == wildcard_code);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= c;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (cmd_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

// ===== hw/rtl/srmq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmq_back
// Holds the ordered entries, scans them one at a time and compacts on removal.
// ----------------------------------------------------------------------------
module srmq_back #(
  parameter int DEPTH       = srmq_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = srmq_pkg::HANDLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  srmq_pkg::cmd_t                cmd,
  input  logic [srmq_pkg::ID_W-1:0]     quit_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srmq_pkg::STATUS_W-1:0] out_status,
  output logic [srmq_pkg::ID_W-1:0]     out_found_id,
  output logic [srmq_pkg::HANDLE_W-1:0] out_found_handle,
  output logic [srmq_pkg::FILL_W-1:0]   out_fill_level
);
  import srmq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [ID_W-1:0]        ids_m [DEPTH];
  logic [HANDLE_BITS-1:0] hnd_m [DEPTH];

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [ID_W-1:0]      rid_r;
  logic [HANDLE_BITS-1:0] rh_r;
  logic                 valid_r, valid_nxt;
  logic [STATUS_W-1:0]  st_r, st_nxt;
  logic [ID_W-1:0]      fid_r, fid_nxt;
  logic [HANDLE_W-1:0]  fh_r, fh_nxt;
  logic [STATUS_W-1:0]  ost_r;
  logic [ID_W-1:0]      ofid_r;
  logic [HANDLE_W-1:0]  ofh_r;
  logic [CW-1:0]        ofill_r;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [ID_W-1:0]      wr_id;
  logic [HANDLE_BITS-1:0] wr_h;
  logic [AW-1:0]        rd_addr;
  logic                 hit_q, hit_r;
  logic [HANDLE_W-1:0]  h16;

  // read port and write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ids_m[wr_addr] <= wr_id;
      hnd_m[wr_addr] <= wr_h;
    end
    rid_r <= ids_m[rd_addr];
    rh_r  <= hnd_m[rd_addr];
  end

  assign hit_q = (rid_r == quit_code);
  assign hit_r = cmd.any || (rid_r >= cmd.range_low && rid_r <= cmd.range_high);

  generate
    if (HANDLE_BITS >= HANDLE_W) begin : g_hw
      assign h16 = rh_r[HANDLE_W-1:0];
    end else begin : g_hn
      assign h16 = {{(HANDLE_W-HANDLE_BITS){1'b0}}, rh_r};
    end
  endgenerate

  assign out_valid        = valid_r;
  assign out_status       = ost_r;
  assign out_found_id     = ofid_r;
  assign out_found_handle = ofh_r;
  assign out_fill_level   = FILL_W'(ofill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
    idx_r <= idx_nxt;
    st_r  <= st_nxt;
    fid_r <= fid_nxt;
    fh_r  <= fh_nxt;
    // hold the result word apart from the working registers
    if (cmd_pop) begin
      ost_r   <= st_r;
      ofid_r  <= fid_r;
      ofh_r   <= fh_r;
      ofill_r <= count_r;
    end
  end

  // sequence add, scan and compaction
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    st_nxt    = st_r;
    fid_nxt   = fid_r;
    fh_nxt    = fh_r;
    cmd_pop   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = AW'(count_r);
    wr_id     = cmd.new_id;
    wr_h      = HANDLE_BITS'(cmd.new_handle);
    rd_addr   = AW'(idx_r);
    if (valid_r && !out_stall) valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        fid_nxt = '0;
        fh_nxt  = '0;
        rd_addr = '0;
        if (cmd_valid) begin
          if (cmd.opcode == OP_ADD) begin
            if (count_r == CW'(DEPTH)) begin
              st_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + 1'b1;
              st_nxt    = ST_ADDED;
            end
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            st_nxt    = ST_NONE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // rid_r holds entry idx_r
        if (hit_q || hit_r) begin
          st_nxt  = hit_q ? ST_QUIT : ST_RECEIVED;
          fid_nxt = rid_r;
          fh_nxt  = h16;
          if (cmd.take_out) begin
            rd_addr   = AW'(idx_r + 1'b1);
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (idx_r + 1'b1 == count_r) begin
          st_nxt    = ST_NONE;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          rd_addr   = AW'(idx_r + 1'b1);
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_SCAN;
      end
      S_SHIFT: begin
        // rid_r holds entry idx_r+1 when inside the list
        if (idx_r + 1'b1 >= count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = AW'(idx_r);
          wr_id   = rid_r;
          wr_h    = rh_r;
          idx_nxt = idx_r + 1'b1;
          rd_addr = AW'(idx_r + 2'd2);
          state_nxt = S_SHIFT;
        end
      end
      S_DONE: begin
        if (!valid_r || !out_stall) begin
          valid_nxt = 1'b1;
          cmd_pop   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_READ && state_nxt == S_SCAN) rd_addr = AW'(idx_r);
  end

endmodule

// ===== hw/rtl/selective_receive_message_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_receive_message_queue_core
// Ordered mailbox of message ids and handles with selective receive.
// ----------------------------------------------------------------------------
// Words are taken one at a time by a front stage into a two-entry command
// queue; a back sequencer executes them against one single-port-write entry
// memory. A receive starts, reads the oldest entry, then reads and compares
// each further entry in turn (memory read then compare); when the found entry
// is removed, the later entries are moved up one place, and then the result
// is presented. A result register lets the next command start while a result
// waits to be taken.
module selective_receive_message_queue_core #(
  parameter int DEPTH       = srmq_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = srmq_pkg::HANDLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [srmq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srmq_pkg::ID_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [srmq_pkg::ID_W-1:0]     in_new_id,
  input  logic [srmq_pkg::HANDLE_W-1:0] in_new_handle,
  input  logic [srmq_pkg::ID_W-1:0]     in_range_low,
  input  logic [srmq_pkg::ID_W-1:0]     in_range_high,
  input  logic                          in_take_out,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srmq_pkg::STATUS_W-1:0] out_status,
  output logic [srmq_pkg::ID_W-1:0]     out_found_id,
  output logic [srmq_pkg::HANDLE_W-1:0] out_found_handle,
  output logic [srmq_pkg::FILL_W-1:0]   out_fill_level
);
  import srmq_pkg::*;

  logic [ID_W-1:0] quit_r, wild_r;
  logic            cmd_valid, cmd_pop;
  cmd_t            cmd;

  // hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quit_r <= 32'd1;
      wild_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUIT:     quit_r <= cfg_wdata;
        REG_WILDCARD: wild_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  srmq_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_new_id, .in_new_handle,
    .in_range_low, .in_range_high, .in_take_out,
    .wildcard_code(wild_r), .cmd_valid, .cmd_pop, .cmd
  );

  srmq_back #(.DEPTH(DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_pop, .cmd, .quit_code(quit_r),
    .out_valid, .out_stall, .out_status, .out_found_id, .out_found_handle,
    .out_fill_level
  );

endmodule
